// ----- rtl/core/mmgs_pkg.sv -----
// ----------------------------------------------------------------------------
// mmgs_pkg: shared types and constants
// Widths, depth and the controller-to-datapath command and status bundles.
// ----------------------------------------------------------------------------
package mmgs_pkg;
   localparam int MaxItems  = 1024;
   localparam int AddrBits  = $clog2(MaxItems);
   localparam int CountBits = AddrBits + 1;
   localparam int ValueBits = 30;
   localparam int BasketBits = 11;
   localparam int GapBits   = ValueBits + 1;

   typedef struct packed {
      logic store;       // write req value at held count
      logic clear_set;   // clear held count and overflow
      logic sort_start;  // begin one sort step over (i,j)
      logic sort_read;   // read store[j-1] and store[j]
      logic sort_load;   // capture store[j] after the second read
      logic sort_swap;   // write back swapped pair
      logic sort_next_i; // advance outer index
      logic sort_dec_j;  // move inner index down
      logic range_rd_lo; // take store[0] as min
      logic range_rd_hi; // read store[count-1]
      logic range_set;   // low = 0, high = max - min
      logic pass_start;  // start greedy pass at mid
      logic pass_step;   // consume one read element
      logic pass_read;   // issue read of index k
      logic pass_fit;    // mid fits
      logic pass_nofit;  // mid does not fit
      logic zero_best;   // best = 0
   } mmgs_cmd_type;

   typedef struct packed {
      logic enough;      // held count >= need
      logic sort_i_done; // i >= held count
      logic sort_j_zero; // j == 0
      logic sort_greater;// store[j-1] > store[j]
      logic search_done; // low > high
      logic pass_fits;   // picked reached need
      logic pass_end;    // all elements scanned
      logic mid_zero;    // mid == 0
   } mmgs_sts_type;
endpackage

// ----- rtl/core/mmgs_datapath.sv -----
// ----------------------------------------------------------------------------
// mmgs_datapath: value store, sort and search registers
// Holds the set in a memory with one write and one read port, performs
// insertion sort steps and greedy scans driven by the controller.
// ----------------------------------------------------------------------------
module mmgs_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [mmgs_pkg::ValueBits-1:0]        in_value,
   input  logic [mmgs_pkg::BasketBits-1:0]       need,
   input  mmgs_pkg::mmgs_cmd_type                cmd,
   output mmgs_pkg::mmgs_sts_type                sts,
   output logic [mmgs_pkg::ValueBits-1:0]        best_gap,
   output logic                                 overflowed
);
   import mmgs_pkg::*;

   logic [ValueBits-1:0] mem [MaxItems];
   logic [ValueBits-1:0] rd_ff;
   logic [ValueBits-1:0] pair_a_ff, pair_b_ff;

   logic [CountBits-1:0] count_ff, count_in;
   logic                 ovf_ff, ovf_in;
   logic [CountBits-1:0] i_ff, i_in;
   logic [CountBits-1:0] j_ff, j_in;
   logic [CountBits-1:0] k_ff, k_in;
   logic [GapBits-1:0]   low_ff, low_in, high_ff, high_in;
   logic [ValueBits-1:0] best_ff, best_in;
   logic [ValueBits-1:0] min_ff, min_in;
   logic [ValueBits-1:0] last_ff, last_in;
   logic [CountBits-1:0] picked_ff, picked_in;
   logic [GapBits-1:0]   mid;
   logic                 fits_ff, fits_in;
   logic                 half_ff, half_in;

   logic                 we;
   logic [AddrBits-1:0]  waddr, raddr;
   logic [ValueBits-1:0] wdata;
   logic [GapBits-1:0]   diff;

   assign mid  = low_ff + ((high_ff - low_ff) >> 1);
   assign diff = {1'b0, rd_ff} - {1'b0, last_ff};

   // One write port: a swap writes store[j-1] first, then store[j].
   always_comb begin
      we    = 1'b0;
      waddr = count_ff[AddrBits-1:0];
      wdata = in_value;
      raddr = '0;
      if (cmd.store && count_ff < CountBits'(MaxItems)) begin
         we = 1'b1;
      end
      if (cmd.sort_swap) begin
         we = 1'b1;
         if (!half_ff) begin
            waddr = AddrBits'(j_ff - 1'b1);
            wdata = pair_b_ff;
         end else begin
            waddr = j_ff[AddrBits-1:0];
            wdata = pair_a_ff;
         end
      end
      if (cmd.sort_read) begin
         raddr = half_ff ? j_ff[AddrBits-1:0] : AddrBits'(j_ff - 1'b1);
      end
      if (cmd.range_rd_hi) raddr = AddrBits'(count_ff - 1'b1);
      if (cmd.pass_read)   raddr = k_ff[AddrBits-1:0];
   end

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rd_ff <= mem[raddr];
   end

   always_comb begin
      count_in  = count_ff;
      ovf_in    = ovf_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      k_in      = k_ff;
      low_in    = low_ff;
      high_in   = high_ff;
      best_in   = best_ff;
      min_in    = min_ff;
      last_in   = last_ff;
      picked_in = picked_ff;
      fits_in   = fits_ff;
      half_in   = half_ff;
      if (cmd.store) begin
         if (count_ff < CountBits'(MaxItems)) count_in = count_ff + 1'b1;
         else ovf_in = 1'b1;
      end
      if (cmd.clear_set) begin
         count_in = '0;
         ovf_in   = 1'b0;
         i_in     = CountBits'(1);
         j_in     = CountBits'(1);
      end
      if (cmd.sort_read) half_in = ~half_ff;
      if (cmd.sort_swap) half_in = ~half_ff;
      if (cmd.sort_start) begin
         j_in    = i_ff;
         half_in = 1'b0;
      end
      if (cmd.sort_dec_j) begin
         j_in    = j_ff - 1'b1;
         half_in = 1'b0;
      end
      if (cmd.sort_next_i) i_in = i_ff + 1'b1;
      if (cmd.range_rd_lo) min_in = rd_ff;
      if (cmd.range_set) begin
         low_in  = '0;
         high_in = {1'b0, rd_ff} - {1'b0, min_ff};
      end
      if (cmd.zero_best) best_in = '0;
      if (cmd.pass_start) begin
         last_in   = min_ff;
         picked_in = CountBits'(1);
         k_in      = CountBits'(1);
         fits_in   = 1'b0;
      end
      if (cmd.pass_read) k_in = k_ff + 1'b1;
      if (cmd.pass_step && !fits_ff && diff >= mid) begin
         last_in   = rd_ff;
         picked_in = picked_ff + 1'b1;
         if (picked_ff + 1'b1 >= {1'b0, need}) fits_in = 1'b1;
      end
      if (cmd.pass_fit) begin
         best_in = mid[ValueBits-1:0];
         low_in  = mid + 1'b1;
      end
      if (cmd.pass_nofit) high_in = mid - 1'b1;
   end

   // Pair capture during a sort step: store[j-1] from the first read is taken
   // during the second read, and store[j] the cycle after it.
   always_ff @(posedge clock) begin
      if (cmd.sort_read && half_ff) pair_a_ff <= rd_ff;
      if (cmd.sort_load) pair_b_ff <= rd_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         ovf_ff    <= 1'b0;
         i_ff      <= CountBits'(1);
         j_ff      <= CountBits'(1);
         k_ff      <= '0;
         low_ff    <= '0;
         high_ff   <= '0;
         best_ff   <= '0;
         picked_ff <= '0;
         fits_ff   <= 1'b0;
         half_ff   <= 1'b0;
      end else begin
         count_ff  <= count_in;
         ovf_ff    <= ovf_in;
         i_ff      <= i_in;
         j_ff      <= j_in;
         k_ff      <= k_in;
         low_ff    <= low_in;
         high_ff   <= high_in;
         best_ff   <= best_in;
         picked_ff <= picked_in;
         fits_ff   <= fits_in;
         half_ff   <= half_in;
      end
      min_ff  <= min_in;
      last_ff <= last_in;
   end

   assign sts.enough       = count_ff >= {1'b0, need};
   assign sts.sort_i_done  = i_ff >= count_ff;
   assign sts.sort_j_zero  = j_ff == '0;
   assign sts.sort_greater = pair_a_ff > pair_b_ff;
   assign sts.search_done  = low_ff > high_ff;
   assign sts.pass_fits    = fits_ff;
   assign sts.pass_end     = k_ff >= count_ff;
   assign sts.mid_zero     = mid == '0;
   assign best_gap   = best_ff;
   assign overflowed = ovf_ff;
endmodule

// ----- rtl/core/mmgs_control.sv -----
// ----------------------------------------------------------------------------
// mmgs_control: sequencer
// Loads the set and, if it holds enough values, steps the insertion sort,
// then runs the binary search with one greedy scan per probe; hands the result to the output register.
// ----------------------------------------------------------------------------
module mmgs_control (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   input  logic                     req_tlast,
   output logic                     req_tready,
   input  logic                     rsp_tready,
   output logic                     rsp_tvalid,
   output logic                     capture,
   output mmgs_pkg::mmgs_cmd_type   cmd,
   input  mmgs_pkg::mmgs_sts_type   sts
);
   import mmgs_pkg::*;

   typedef enum logic [13:0] {
      S_LOAD    = 14'd1,
      S_CHECK   = 14'd2,
      S_SORT_I  = 14'd4,
      S_SORT_R0 = 14'd8,
      S_SORT_R1 = 14'd16,
      S_SORT_C  = 14'd32,
      S_SORT_W1 = 14'd64,
      S_RANGE0  = 14'd128,
      S_RANGE1  = 14'd256,
      S_RANGE2  = 14'd512,
      S_PROBE   = 14'd1024,
      S_SCAN    = 14'd2048,
      S_DONE    = 14'd4096,
      S_EMIT    = 14'd8192
   } state_type;

   state_type state_ff, state_in;
   logic      rvalid_ff, rvalid_in;
   logic      scan_wait_ff, scan_wait_in;

   // The output register holds a finished result, so the next set may load
   // while that result waits.
   assign req_tready = (state_ff == S_LOAD);
   assign rsp_tvalid = rvalid_ff;

   always_comb begin
      state_in     = state_ff;
      rvalid_in    = rvalid_ff && !rsp_tready;
      scan_wait_in = 1'b0;
      cmd          = '0;
      capture      = 1'b0;
      unique case (state_ff)
         S_LOAD: begin
            if (req_tvalid && req_tready) begin
               cmd.store = 1'b1;
               if (req_tlast) state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            cmd.zero_best = 1'b1;
            state_in = sts.enough ? S_SORT_I : S_DONE;
         end
         S_SORT_I: begin
            if (sts.sort_i_done) state_in = S_RANGE0;
            else begin
               cmd.sort_start = 1'b1;
               state_in = S_SORT_R0;
            end
         end
         S_SORT_R0: begin
            if (sts.sort_j_zero) begin
               cmd.sort_next_i = 1'b1;
               state_in = S_SORT_I;
            end else begin
               cmd.sort_read = 1'b1;
               state_in = S_SORT_R1;
            end
         end
         S_SORT_R1: begin
            cmd.sort_read = 1'b1;
            state_in = S_SORT_C;
         end
         S_SORT_C: begin
            // The second read returns here and lands in the pair register.
            cmd.sort_load = 1'b1;
            state_in = S_SORT_W1;
         end
         S_SORT_W1: begin
            if (!sts.sort_greater) begin
               cmd.sort_next_i = 1'b1;
               state_in = S_SORT_I;
            end else begin
               cmd.sort_swap = 1'b1;
               state_in = S_SORT_W1;
               if (scan_wait_ff) begin
                  cmd.sort_dec_j = 1'b1;
                  state_in = S_SORT_R0;
               end else scan_wait_in = 1'b1;
            end
         end
         S_RANGE0: begin
            state_in = S_RANGE1;
         end
         S_RANGE1: begin
            cmd.range_rd_lo = 1'b1;
            cmd.range_rd_hi = 1'b1;
            state_in = S_RANGE2;
         end
         S_RANGE2: begin
            cmd.range_set = 1'b1;
            state_in = S_PROBE;
         end
         S_PROBE: begin
            if (sts.search_done) state_in = S_DONE;
            else begin
               cmd.pass_start = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            // Reads are issued one ahead; scan_wait marks valid read data.
            if (scan_wait_ff) cmd.pass_step = 1'b1;
            if (sts.pass_fits) begin
               cmd.pass_fit = 1'b1;
               state_in = S_PROBE;
            end else if (sts.pass_end && !scan_wait_ff) begin
               if (sts.mid_zero) state_in = S_DONE;
               else begin
                  cmd.pass_nofit = 1'b1;
                  state_in = S_PROBE;
               end
            end else if (!sts.pass_end) begin
               cmd.pass_read = 1'b1;
               scan_wait_in  = 1'b1;
            end
         end
         S_DONE: begin
            if (!rvalid_ff) begin
               capture   = 1'b1;
               rvalid_in = 1'b1;
               state_in  = S_EMIT;
            end
         end
         S_EMIT: begin
            cmd.clear_set = 1'b1;
            state_in = S_LOAD;
         end
         default: state_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         rvalid_ff    <= 1'b0;
         scan_wait_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rvalid_ff    <= rvalid_in;
         scan_wait_ff <= scan_wait_in;
      end
   end
endmodule

// ----- rtl/core/max_min_gap_selection.sv -----
// Operation: accepts one value per cycle while in its load state; once a set of
// enough values is in, insertion sort and up to 31 greedy scans, one per probe.
// Throughput: one set at a time; the next set may load while a result waits.
// Reset: synchronous, active high; clears counts, search state and the
// output valid; basket_size returns to 2. The store contents are not cleared.
// ----------------------------------------------------------------------------
// max_min_gap_selection: largest minimum gap over a chosen subset
// Collects a set, sorts it and binary-searches the best gap for basket_size.
// ----------------------------------------------------------------------------
module max_min_gap_selection (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [31:0]  req_tdata,   // [29:0] value
   input  logic         req_tlast,   // is_last
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [31:0]  rsp_tdata,   // [29:0] best_gap, [30] overflowed
   input  logic         csr_we,
   input  logic [10:0]  csr_wdata
);
   import mmgs_pkg::*;

   logic [BasketBits-1:0] basket_ff;
   logic [BasketBits-1:0] need;
   mmgs_cmd_type          cmd;
   mmgs_sts_type          sts;
   logic                  capture;
   logic [ValueBits-1:0]  best_gap;
   logic                  overflowed;
   logic [ValueBits-1:0]  out_gap_ff;
   logic                  out_ovf_ff;

   assign need = (basket_ff < BasketBits'(2)) ? BasketBits'(2) : basket_ff;

   always_ff @(posedge clock) begin
      if (reset) basket_ff <= BasketBits'(2);
      else if (csr_we) basket_ff <= csr_wdata;
      if (capture) begin
         out_gap_ff <= best_gap;
         out_ovf_ff <= overflowed;
      end
   end

   mmgs_control u_control (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .capture    (capture),
      .cmd        (cmd),
      .sts        (sts)
   );

   mmgs_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .in_value   (req_tdata[ValueBits-1:0]),
      .need       (need),
      .cmd        (cmd),
      .sts        (sts),
      .best_gap   (best_gap),
      .overflowed (overflowed)
   );

   assign rsp_tdata = {1'b0, out_ovf_ff, out_gap_ff};
endmodule

// ----- test/max_min_gap_selection_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// max_min_gap_selection_checker: gap predictor and result scoreboard
// Watches the value stream and the register port, predicts the best gap of
// each completed set and compares every result transaction with it.
// ----------------------------------------------------------------------------
module max_min_gap_selection_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [10:0] csr_wdata,
   output int          pending_sets,
   output int          mismatch_count
);
   import mmgs_pkg::*;

   typedef struct packed {
      logic [ValueBits-1:0] best_gap;
      logic                 overflowed;
   } gap_result_type;

   logic [ValueBits-1:0]  set_values[$];
   logic                  set_overflow = 1'b0;
   logic [BasketBits-1:0] basket = 11'd2;
   gap_result_type        gap_expect[$];

   initial begin
      pending_sets   = 0;
      mismatch_count = 0;
   end

   // Greedy scan: can need values be picked, each at least gap above the last?
   function automatic bit gap_reachable(longint gap, int need);
      int     picked;
      longint prev;
      picked = 1;
      prev   = set_values[0];
      for (int i = 1; i < set_values.size(); i++) begin
         if (longint'(set_values[i]) - prev >= gap) begin
            picked++;
            prev = set_values[i];
            if (picked >= need) return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic gap_result_type best_gap_of_set();
      gap_result_type       res;
      int                   need;
      int                   j;
      longint               lo, hi, mid, best;
      logic [ValueBits-1:0] key;
      need = (basket < 2) ? 2 : int'(basket);
      best = 0;
      if (set_values.size() >= need) begin
         for (int i = 1; i < set_values.size(); i++) begin
            key = set_values[i];
            j   = i;
            while (j > 0 && set_values[j-1] > key) begin
               set_values[j] = set_values[j-1];
               j--;
            end
            set_values[j] = key;
         end
         lo = 0;
         hi = longint'(set_values[set_values.size()-1]) - longint'(set_values[0]);
         while (lo <= hi) begin
            mid = lo + (hi - lo) / 2;
            if (gap_reachable(mid, need)) begin
               best = mid;
               lo   = mid + 1;
            end else begin
               if (mid == 0) break;
               hi = mid - 1;
            end
         end
      end
      res.best_gap   = best[ValueBits-1:0];
      res.overflowed = set_overflow;
      return res;
   endfunction

   always @(posedge clock) begin
      gap_result_type want;
      int             errs;
      errs = 0;
      if (!reset) begin
         if (csr_we) basket <= csr_wdata;
         if (req_tvalid && req_tready) begin
            if (set_values.size() < MaxItems)
               set_values.push_back(req_tdata[ValueBits-1:0]);
            else
               set_overflow = 1'b1;
            if (req_tlast) begin
               gap_expect.push_back(best_gap_of_set());
               set_values.delete();
               set_overflow = 1'b0;
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (gap_expect.size() == 0) begin
               $error("unexpected result transaction: tdata %h", rsp_tdata);
               errs++;
            end else begin
               want = gap_expect.pop_front();
               if (rsp_tdata[ValueBits-1:0] !== want.best_gap) begin
                  $error("best_gap: expected %0d, actual %0d", want.best_gap,
                         rsp_tdata[ValueBits-1:0]);
                  errs++;
               end
               if (rsp_tdata[ValueBits] !== want.overflowed) begin
                  $error("overflowed: expected %0b, actual %0b", want.overflowed,
                         rsp_tdata[ValueBits]);
                  errs++;
               end
            end
         end
         mismatch_count <= mismatch_count + errs;
         pending_sets   <= gap_expect.size();
      end
   end
endmodule

// ----- test/tb_max_min_gap_selection.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_max_min_gap_selection: testbench top for the best gap selector
// Drives value sets and basket sizes with random idling on both streams and
// reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_max_min_gap_selection;
   import mmgs_pkg::*;

   localparam int CycleLimit = 5000000;
   localparam int ValueMax   = (1 << ValueBits) - 1;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // [29:0] value
   logic        req_tlast = 1'b0; // is_last
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;       // [29:0] best_gap, [30] overflowed
   logic        csr_we = 1'b0;
   logic [10:0] csr_wdata = '0;

   int pending_sets;
   int mismatch_count;
   int send_idle_pct  = 0;
   int stall_pct      = 0;
   int values_sent    = 0;
   int cycle_count    = 0;
   bit hold_toggle    = 1'b0;

   max_min_gap_selection dut (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tlast,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .csr_we, .csr_wdata
   );

   max_min_gap_selection_checker checker_i (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tlast,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .csr_we, .csr_wdata,
      .pending_sets, .mismatch_count
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Result side: random stalls, plus a long hold-off whenever the top asks.
   always @(posedge clock) begin
      int hold_left;
      bit seen_toggle;
      if (hold_toggle != seen_toggle) begin
         seen_toggle = hold_toggle;
         hold_left   = 3000;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic send_value(input logic [ValueBits-1:0] v, input bit last);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, v};
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      values_sent++;
   endtask

   // The block is idle only once every set has produced its result.
   task automatic write_basket(input logic [10:0] size);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_sets != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= size;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // Shapes: full range, narrow range with many duplicates, or ascending.
   task automatic send_random_set(input int count);
      int  shape;
      longint v;
      shape = $urandom_range(2);
      v = $urandom_range(1, 1000);
      for (int i = 0; i < count; i++) begin
         if (shape == 0)
            v = $urandom_range(1, ValueMax);
         else if (shape == 1)
            v = $urandom_range(1, 20);
         else
            v = (v + $urandom_range(0, 5000) > ValueMax) ? ValueMax
                : v + $urandom_range(0, 5000);
         send_value(v[ValueBits-1:0], i == count - 1);
      end
   endtask

   initial begin
      int sizes[4];
      sizes = '{0, 80, 0, 33};
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: lone value, widest gap, equal values, baskets 0,1,3,2047.
      send_value(30'd1, 1'b1);
      send_value(30'd1, 1'b0);
      send_value(ValueBits'(ValueMax), 1'b1);
      send_value(30'd5, 1'b0);
      send_value(30'd5, 1'b0);
      send_value(30'd5, 1'b1);
      write_basket(11'd0);
      send_value(30'd10, 1'b0);
      send_value(30'd3, 1'b0);
      send_value(30'd7, 1'b1);
      write_basket(11'd1);
      send_value(30'd4, 1'b0);
      send_value(30'd9, 1'b1);
      write_basket(11'd3);
      send_value(30'd16, 1'b0);
      send_value(30'd1, 1'b0);
      send_value(30'd8, 1'b0);
      send_value(30'd2, 1'b0);
      send_value(30'd4, 1'b1);
      write_basket(11'd2047);
      send_value(30'd1, 1'b0);
      send_value(30'd2, 1'b1);

      for (int phase = 0; phase < 4; phase++) begin
         write_basket($urandom_range(3) == 0 ? 11'($urandom_range(0, 2047))
                                             : 11'($urandom_range(2, 6)));
         send_idle_pct = (phase == 1 || phase == 3) ? sizes[phase] : 0;
         stall_pct     = (phase == 2) ? 80 : (phase == 3) ? 33 : 0;
         if (phase == 0) hold_toggle = ~hold_toggle;
         while (values_sent < 16 + (phase + 1) * 209) begin
            send_random_set($urandom_range(9) == 0 ? $urandom_range(20, 40)
                                                   : $urandom_range(1, 10));
            if ($urandom_range(7) == 0) begin
               write_basket(11'($urandom_range(2, 8)));
            end
         end
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_sets != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (mismatch_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule
